FILE: rtl/cpa_pkg.sv
// Shared widths, status codes and types for the convex polygon area block.
package cpa_pkg;

    localparam int SUM_W  = 48;
    localparam int AREA_W = 34;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_CONVEX = 2'd1,
        ST_ZERO_AREA  = 2'd2,
        ST_TOO_MANY   = 2'd3
    } status_t;

    typedef logic signed [SUM_W-1:0] sum_t;

endpackage

FILE: rtl/cpa_sat_add.sv
// Saturating signed accumulator add for the shoelace sum.
module cpa_sat_add
    import cpa_pkg::*;
#(
    parameter int TERM_W = 34
)
(
    input  sum_t                     acc,
    input  logic signed [TERM_W-1:0] term,
    input  logic                     term_en,
    output sum_t                     sum
);

    localparam int AW = ((TERM_W > SUM_W) ? TERM_W : SUM_W) + 1;

    logic signed [AW-1:0] acc_ext;
    logic signed [AW-1:0] term_ext;
    logic signed [AW-1:0] raw;
    logic signed [AW-1:0] lim_hi;
    logic signed [AW-1:0] lim_lo;

    assign acc_ext  = AW'(acc);
    assign term_ext = term_en ? AW'(term) : '0;
    assign raw      = acc_ext + term_ext;
    assign lim_hi   = {{(AW-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
    assign lim_lo   = -lim_hi;

    always_comb
    begin
        if (raw > lim_hi)
            sum = lim_hi[SUM_W-1:0];
        else if (raw < lim_lo)
            sum = lim_lo[SUM_W-1:0];
        else
            sum = raw[SUM_W-1:0];
    end

endmodule

FILE: rtl/convex_polygon_area_core.sv
// Streaming doubled shoelace area with convexity test, one vertex word per cycle.
// Throughput: one vertex word per cycle; the whole five-register pipeline stalls together
// only while a finished result word waits at the output.
// Reset (rst_n low, asynchronous): pipeline empty, polygon state cleared, convex flag set.
module convex_polygon_area_core
    import cpa_pkg::*;
#(
    parameter int MAX_VERTICES = 4096,
    parameter int COORD_BITS   = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] vert_x,
    input  logic signed [COORD_BITS-1:0] vert_y,
    input  logic                         is_last,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [AREA_W-1:0]            twice_area,
    output logic [1:0]                   status
);

    // Differences and sums of two coordinates take one extra bit; products twice that.
    localparam int DW    = COORD_BITS + 1;
    localparam int PW    = 2 * DW;
    localparam int CNT_W = $clog2(MAX_VERTICES + 2);

    // Whole pipeline advances together whenever the output register can take a word.
    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic                         v1_reg;
    logic signed [COORD_BITS-1:0] x1_reg, y1_reg;
    logic                         last1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            x1_reg    <= vert_x;
            y1_reg    <= vert_y;
            last1_reg <= is_last;
        end
    end

    // ------------------------------------------------------------------
    // Polygon geometry state: first two vertices, two most recent, count
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic signed [COORD_BITS-1:0] f0x_reg, f0y_reg, f1x_reg, f1y_reg;
    logic signed [COORD_BITS-1:0] r0x_reg, r0y_reg, r1x_reg, r1y_reg;
    logic signed [COORD_BITS-1:0] f0x_next, f0y_next, f1x_next, f1y_next;
    logic signed [COORD_BITS-1:0] r0x_next, r0y_next, r1x_next, r1y_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        f0x_next = f0x_reg;
        f0y_next = f0y_reg;
        f1x_next = f1x_reg;
        f1y_next = f1y_reg;
        r0x_next = r0x_reg;
        r0y_next = r0y_reg;
        r1x_next = r1x_reg;
        r1y_next = r1y_reg;
        if (v1_reg)
        begin
            if (last1_reg)
            begin
                // closing vertex: start the next polygon from scratch
                cnt_next = '0;
                f0x_next = '0;
                f0y_next = '0;
                f1x_next = '0;
                f1y_next = '0;
                r0x_next = '0;
                r0y_next = '0;
                r1x_next = '0;
                r1y_next = '0;
            end
            else
            begin
                if (cnt_reg == CNT_W'(0))
                begin
                    f0x_next = x1_reg;
                    f0y_next = y1_reg;
                end
                if (cnt_reg == CNT_W'(1))
                begin
                    f1x_next = x1_reg;
                    f1y_next = y1_reg;
                end
                // saturate one above the limit so an overlong polygon stays flagged
                if (cnt_reg < CNT_W'(MAX_VERTICES + 1))
                    cnt_next = cnt_reg + CNT_W'(1);
                r0x_next = r1x_reg;
                r0y_next = r1y_reg;
                r1x_next = x1_reg;
                r1y_next = y1_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            f0x_reg <= '0;
            f0y_reg <= '0;
            f1x_reg <= '0;
            f1y_reg <= '0;
            r0x_reg <= '0;
            r0y_reg <= '0;
            r1x_reg <= '0;
            r1y_reg <= '0;
        end
        else if (en)
        begin
            cnt_reg <= cnt_next;
            f0x_reg <= f0x_next;
            f0y_reg <= f0y_next;
            f1x_reg <= f1x_next;
            f1y_reg <= f1y_next;
            r0x_reg <= r0x_next;
            r0y_reg <= r0y_next;
            r1x_reg <= r1x_next;
            r1y_reg <= r1y_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: shoelace terms and corner cross-product halves
    // ------------------------------------------------------------------
    logic signed [DW-1:0] cx, cy, p1x, p1y, p0x, p0y, q0x, q0y, q1x, q1y;

    // A one-vertex polygon closes on itself: the first vertex is the current one.
    assign cx  = DW'(x1_reg);
    assign cy  = DW'(y1_reg);
    assign p0x = DW'(r0x_reg);
    assign p0y = DW'(r0y_reg);
    assign p1x = DW'(r1x_reg);
    assign p1y = DW'(r1y_reg);
    assign q0x = (cnt_reg == CNT_W'(0)) ? cx : DW'(f0x_reg);
    assign q0y = (cnt_reg == CNT_W'(0)) ? cy : DW'(f0y_reg);
    assign q1x = DW'(f1x_reg);
    assign q1y = DW'(f1y_reg);

    logic signed [PW-1:0] t1, t2, ca1, ca2, cb1, cb2, cc1, cc2;

    // term for the edge from the previous vertex to the current one
    assign t1  = (p1x + cx) * (p1y - cy);
    // closing edge back to the first vertex
    assign t2  = (cx + q0x) * (cy - q0y);
    // corner at previous vertex: (cur - prev) x (prev2 - prev)
    assign ca1 = (cx - p1x) * (p0y - p1y);
    assign ca2 = (cy - p1y) * (p0x - p1x);
    // wrap corner at the current vertex
    assign cb1 = (q0x - cx) * (p1y - cy);
    assign cb2 = (q0y - cy) * (p1x - cx);
    // wrap corner at the first vertex
    assign cc1 = (q1x - q0x) * (cy - q0y);
    assign cc2 = (q1y - q0y) * (cx - q0x);

    logic                 v2_reg;
    logic signed [PW-1:0] t1_reg, t2_reg;
    logic signed [PW-1:0] ca1_reg, ca2_reg, cb1_reg, cb2_reg, cc1_reg, cc2_reg;
    logic                 use_t1_reg, use_ca_reg, ca_first_reg, chk_close_reg;
    logic                 too_many2_reg, last2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en && v1_reg)
        begin
            t1_reg        <= t1;
            t2_reg        <= t2;
            ca1_reg       <= ca1;
            ca2_reg       <= ca2;
            cb1_reg       <= cb1;
            cb2_reg       <= cb2;
            cc1_reg       <= cc1;
            cc2_reg       <= cc2;
            use_t1_reg    <= cnt_reg >= CNT_W'(1);
            use_ca_reg    <= cnt_reg >= CNT_W'(2);
            ca_first_reg  <= cnt_reg == CNT_W'(2);
            chk_close_reg <= cnt_reg >= CNT_W'(3);
            too_many2_reg <= cnt_reg >= CNT_W'(MAX_VERTICES);
            last2_reg     <= last1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: running sum and turn-direction bookkeeping
    // ------------------------------------------------------------------
    sum_t sum_reg, sum_next, sum1;
    logic turn_reg, turn_next, convex_reg, convex_next;
    logic pos_a, pos_b, pos_c, turn_eff, convex_eff, convex_fin;

    cpa_sat_add #(.TERM_W(PW)) u_add_edge (
        .acc     (sum_reg),
        .term    (t1_reg),
        .term_en (use_t1_reg),
        .sum     (sum1)
    );

    // a zero cross product counts as "not positive"
    assign pos_a      = ca1_reg > ca2_reg;
    assign pos_b      = cb1_reg > cb2_reg;
    assign pos_c      = cc1_reg > cc2_reg;
    assign turn_eff   = (use_ca_reg && ca_first_reg) ? pos_a : turn_reg;
    assign convex_eff = convex_reg && !(use_ca_reg && !ca_first_reg && (pos_a != turn_reg));
    assign convex_fin = convex_eff && (pos_b == turn_eff) && (pos_c == turn_eff);

    always_comb
    begin
        sum_next    = sum_reg;
        turn_next   = turn_reg;
        convex_next = convex_reg;
        if (v2_reg)
        begin
            if (last2_reg)
            begin
                sum_next    = '0;
                turn_next   = 1'b0;
                convex_next = 1'b1;
            end
            else
            begin
                sum_next    = sum1;
                turn_next   = turn_eff;
                convex_next = convex_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            turn_reg   <= 1'b0;
            convex_reg <= 1'b1;
        end
        else if (en)
        begin
            sum_reg    <= sum_next;
            turn_reg   <= turn_next;
            convex_reg <= convex_next;
        end
    end

    // Only closing vertices go on past this point.
    logic                 v3_reg;
    sum_t                 sum3_reg;
    logic signed [PW-1:0] t2_3_reg;
    logic                 too_many3_reg, not_convex3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg && last2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en && v2_reg && last2_reg)
        begin
            sum3_reg        <= sum1;
            t2_3_reg        <= t2_reg;
            too_many3_reg   <= too_many2_reg;
            not_convex3_reg <= chk_close_reg && !convex_fin;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: add the closing edge
    // ------------------------------------------------------------------
    sum_t sum2;

    cpa_sat_add #(.TERM_W(PW)) u_add_close (
        .acc     (sum3_reg),
        .term    (t2_3_reg),
        .term_en (1'b1),
        .sum     (sum2)
    );

    logic v4_reg;
    sum_t sum4_reg;
    logic too_many4_reg, not_convex4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en && v3_reg)
        begin
            sum4_reg        <= sum2;
            too_many4_reg   <= too_many3_reg;
            not_convex4_reg <= not_convex3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: status, magnitude and clamp into the output register
    // ------------------------------------------------------------------
    sum_t              mag;
    logic [AREA_W-1:0] area_clamped;
    status_t           st;
    logic [AREA_W-1:0] area_word;

    // sum is held within +-(2^47 - 1), so negation never overflows
    assign mag          = sum4_reg[SUM_W-1] ? -sum4_reg : sum4_reg;
    assign area_clamped = (mag[SUM_W-1:AREA_W] != '0) ? '1 : mag[AREA_W-1:0];

    always_comb
    begin
        area_word = '0;
        if (too_many4_reg)
            st = ST_TOO_MANY;
        else if (not_convex4_reg)
            st = ST_NOT_CONVEX;
        else if (sum4_reg == '0)
            st = ST_ZERO_AREA;
        else
        begin
            st        = ST_OK;
            area_word = area_clamped;
        end
    end

    logic              out_valid_reg;
    logic [AREA_W-1:0] area_reg;
    logic [1:0]        status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en && v4_reg)
        begin
            area_reg   <= area_word;
            status_reg <= st;
        end
    end

    assign out_valid  = out_valid_reg;
    assign twice_area = area_reg;
    assign status     = status_reg;

`ifndef SYNTHESIS
    a_area_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> twice_area == '0)
        else $error("area word nonzero with failing status");

    a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OK) |-> twice_area != '0)
        else $error("ok status with zero area");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_VERTICES + 1))
        else $error("vertex count past saturation point");

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        en && v1_reg && last1_reg |=> cnt_reg == '0)
        else $error("vertex count not cleared after closing vertex");

    a_sum_clears: assert property (@(posedge clk) disable iff (!rst_n)
        en && v2_reg && last2_reg |=> sum_reg == '0 && convex_reg)
        else $error("polygon sum state not cleared after closing vertex");
`endif

endmodule
